@@ design/mh1_pkg.sv @@
// Shared types and constants for the 32-bit MurmurHash1 engine.
// No dependencies; the front, queue, back and core files refer to this package by scope.
package mh1_pkg;

  localparam logic [31:0] MUR_MULT    = 32'hc6a4a793;
  localparam int          MUR_SHIFT   = 16;
  localparam int          FIN_SHIFT_A = 10;
  localparam int          FIN_SHIFT_B = 17;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int               PADDR_W   = 3;
  localparam logic [PADDR_W-1:0] ADDR_SEED = 3'd0;

  // One classified key word, as handed from front to back.
  typedef struct packed {
    logic [31:0] word;   // key word with unused high bytes cleared
    logic [31:0] start;  // seed ^ (key_length * multiplier)
    logic        first;
    logic        mix;    // word carries at least one byte
    logic        last;
  } mh1_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_FIN1,
    S_FIN2
  } mh1_state_t;

endpackage

@@ design/mh1_key_if.sv @@
// Key word channel: valid/ready handshake with the input item fields.
// Depends on nothing.
interface mh1_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;
  logic [2:0]  valid_bytes;
  logic        first_word;
  logic        last_word;
  logic [31:0] key_length;

  modport source (output valid, key_word, valid_bytes, first_word, last_word, key_length,
                  input ready);
  modport sink (input valid, key_word, valid_bytes, first_word, last_word, key_length,
                output ready);
endinterface

@@ design/mh1_hash_if.sv @@
// Hash result channel: valid/ready handshake with the finished hash.
// Depends on nothing.
interface mh1_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

@@ design/mh1_front.sv @@
// Front end: accepts key word beats, masks the word and forms the start value.
// Depends on mh1_pkg and mh1_key_if.
module mh1_front (
  input  logic                 full,
  input  logic [31:0]          seed,
  mh1_key_if.sink              key_in,
  output logic                 push,
  output mh1_pkg::mh1_entry_t  entry
);

  logic [31:0] mask;
  logic [31:0] len_prod;

  always_comb begin
    case (key_in.valid_bytes)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;  // four or more: whole word
    endcase
  end

  assign len_prod = key_in.key_length * mh1_pkg::MUR_MULT;

  assign key_in.ready = !full;
  assign push         = key_in.valid && !full;

  assign entry.word  = key_in.key_word & mask;
  assign entry.start = seed ^ len_prod;
  assign entry.first = key_in.first_word;
  assign entry.mix   = (key_in.valid_bytes != 3'd0);
  assign entry.last  = key_in.last_word;

endmodule

@@ design/mh1_queue.sv @@
// Two-entry queue of classified key words between front and back.
// Depends on mh1_pkg.
module mh1_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mh1_pkg::mh1_entry_t  wr_entry,
  input  logic                 pop,
  output mh1_pkg::mh1_entry_t  rd_entry,
  output logic                 full,
  output logic                 empty
);

  mh1_pkg::mh1_entry_t             slots [mh1_pkg::QUEUE_DEPTH];
  logic [mh1_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mh1_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mh1_pkg::QCNT_W-1:0]      count;

  assign full     = (count == mh1_pkg::QCNT_W'(mh1_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/mh1_back.sv @@
// Back end: mixes queued words into the running hash, finalizes on last words.
// Depends on mh1_pkg and mh1_hash_if; one shared constant multiplier.
module mh1_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  mh1_pkg::mh1_entry_t  entry,
  output logic                 pop,
  mh1_hash_if.source           hash_out
);

  mh1_pkg::mh1_state_t state;
  mh1_pkg::mh1_state_t state_next;

  logic [31:0] running_hash;
  logic [31:0] acc;
  logic [31:0] prod;
  logic [31:0] base;
  logic [31:0] hash_reg;
  logic        out_valid;
  logic        cur_last;
  logic        out_free;
  logic        load_acc;
  logic        load_out;

  assign prod     = acc * mh1_pkg::MUR_MULT;
  assign base     = entry.first ? entry.start : running_hash;
  assign out_free = !out_valid || hash_out.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      mh1_pkg::S_IDLE: begin
        if (!empty) begin
          if (entry.mix) begin
            state_next = mh1_pkg::S_MIX;
          end else if (entry.last) begin
            state_next = mh1_pkg::S_FIN1;
          end
        end
      end
      mh1_pkg::S_MIX: begin
        state_next = cur_last ? mh1_pkg::S_FIN1 : mh1_pkg::S_IDLE;
      end
      mh1_pkg::S_FIN1: begin
        state_next = mh1_pkg::S_FIN2;
      end
      mh1_pkg::S_FIN2: begin
        if (out_free) begin
          state_next = mh1_pkg::S_IDLE;
        end
      end
      default: state_next = mh1_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_acc = 1'b0;
    load_out = 1'b0;
    unique case (state)
      mh1_pkg::S_IDLE: begin
        pop      = !empty;
        load_acc = !empty;
      end
      mh1_pkg::S_MIX:  load_acc = 1'b1;
      mh1_pkg::S_FIN1: load_acc = 1'b1;
      mh1_pkg::S_FIN2: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mh1_pkg::S_IDLE;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && !entry.mix) begin
        running_hash <= base;
      end else if (state == mh1_pkg::S_MIX) begin
        running_hash <= prod ^ (prod >> mh1_pkg::MUR_SHIFT);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (hash_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      unique case (state)
        mh1_pkg::S_IDLE: acc <= base + entry.word;
        mh1_pkg::S_MIX:  acc <= prod ^ (prod >> mh1_pkg::MUR_SHIFT);
        mh1_pkg::S_FIN1: acc <= prod ^ (prod >> mh1_pkg::FIN_SHIFT_A);
        default:         acc <= acc;
      endcase
    end
    if (pop) begin
      cur_last <= entry.last;
    end
    if (load_out) begin
      hash_reg <= prod ^ (prod >> mh1_pkg::FIN_SHIFT_B);
    end
  end

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = hash_reg;

  a_fin_chain: assert property (@(posedge clk) disable iff (rst)
    state == mh1_pkg::S_FIN1 |=> state == mh1_pkg::S_FIN2)
    else $error("second final round did not follow the first");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == mh1_pkg::S_FIN2)
    else $error("hash beat raised outside the last final round");

  a_mix_entry: assert property (@(posedge clk) disable iff (rst)
    state == mh1_pkg::S_MIX |-> $past(state) == mh1_pkg::S_IDLE && $past(pop))
    else $error("mix round entered without a popped word");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != mh1_pkg::S_IDLE |-> !pop)
    else $error("queue popped while a word is in progress");

endmodule

@@ design/murmur1_hash_engine_core.sv @@
// MurmurHash1 32-bit engine: front end, two-entry word queue, mixing back end.
// A last word's beat is queued; the back end pops it in S_IDLE, mixes it in S_MIX,
// finalizes it in S_FIN1 and S_FIN2 and registers the hash; a word with no valid
// bytes skips S_MIX. The back end's shared multiplier serves one word at a time: no
// word is popped before the current one leaves S_MIX, or S_FIN2 if last.
// Reset (rst, synchronous): seed and running hash to zero, queue empty, no hash pending.
module murmur1_hash_engine_core (
  input  logic                        clk,
  input  logic                        rst,
  mh1_key_if.sink                     key_in,
  mh1_hash_if.source                  hash_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mh1_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                seed_wr;
  logic [31:0]         seed;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  mh1_pkg::mh1_entry_t wr_entry;
  mh1_pkg::mh1_entry_t rd_entry;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && pready && (paddr == mh1_pkg::ADDR_SEED);
  assign prdata  = (paddr == mh1_pkg::ADDR_SEED) ? seed : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_wr) begin
      seed <= pwdata;
    end
  end

  mh1_front u_front (
    .full   (full),
    .seed   (seed),
    .key_in (key_in),
    .push   (push),
    .entry  (wr_entry)
  );

  mh1_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .full     (full),
    .empty    (empty)
  );

  mh1_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .entry    (rd_entry),
    .pop      (pop),
    .hash_out (hash_out)
  );

endmodule
